/* rtl/oqsd_pkg.sv */
`default_nettype none

package oqsd_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KEY_W_DEFAULT = 32;

    localparam int ACTION_W = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_MEMBER = 3'd2,
        ACT_HEAD   = 3'd3,
        ACT_NEXT   = 3'd4,
        ACT_READ   = 3'd5
    } action_t;

endpackage

`default_nettype wire

/* rtl/oqsd_ram.sv */
`default_nettype none

module oqsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/ordered_queue_search_delete.sv */
// from accept: append, unknown action and empty-queue cases load the result directly,
// cursor actions returning a key read the ram first, a membership test scans for the key,
// delete scans, then closes the gap (one entry read per cycle by the single ram read port)
// one transaction in flight; the next is taken once the result register is loaded
// synchronous active-low reset: queue empty, cursor at none, no result pending;
// stored keys are not cleared
`default_nettype none

module ordered_queue_search_delete
    import oqsd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int KEY_W = KEY_W_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [ACTION_W-1:0]          s_action,
    input  wire logic [KEY_W-1:0]             s_key,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_status,
    output logic                              m_found,
    output logic                              m_item_valid,
    output logic      [KEY_W-1:0]             m_item_key,
    output logic      [$clog2(DEPTH+1)-1:0]   m_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [CW-1:0] NONE_POS = CW'(DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_SHIFT = 6'b001000,
        ST_READ  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    action_t           action_reg, action_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     held_reg, held_next;
    logic [CW-1:0]     cursor_reg, cursor_next;
    logic              res_status_reg, res_status_next;
    logic              res_found_reg, res_found_next;
    logic              res_ivalid_reg, res_ivalid_next;
    logic [KEY_W-1:0]  res_key_reg, res_key_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_status_reg, m_status_next;
    logic              m_found_reg, m_found_next;
    logic              m_item_valid_reg, m_item_valid_next;
    logic [KEY_W-1:0]  m_item_key_reg, m_item_key_next;
    logic [CW-1:0]     m_count_reg, m_count_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [KEY_W-1:0]  ram_rdata;

    logic              accept;
    logic              cursor_ok;
    logic              key_match;
    logic [CW-1:0]     idx_inc;
    logic [CW-1:0]     idx_inc2;
    logic [CW-1:0]     cursor_inc;

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign cursor_ok    = (cursor_reg < held_reg);
    assign key_match    = (ram_rdata == key_reg);
    assign idx_inc      = idx_reg + CW'(1);
    assign idx_inc2     = idx_reg + CW'(2);
    assign cursor_inc   = cursor_reg + CW'(1);

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_found      = m_found_reg;
    assign m_item_valid = m_item_valid_reg;
    assign m_item_key   = m_item_key_reg;
    assign m_count      = m_count_reg;

    oqsd_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next        = state_reg;
        action_next       = action_reg;
        key_next          = key_reg;
        idx_next          = idx_reg;
        held_next         = held_reg;
        cursor_next       = cursor_reg;
        res_status_next   = res_status_reg;
        res_found_next    = res_found_reg;
        res_ivalid_next   = res_ivalid_reg;
        res_key_next      = res_key_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_found_next      = m_found_reg;
        m_item_valid_next = m_item_valid_reg;
        m_item_key_next   = m_item_key_reg;
        m_count_next      = m_count_reg;
        ram_we            = 1'b0;
        ram_waddr         = idx_reg[AW-1:0];
        ram_wdata         = ram_rdata;
        ram_raddr         = idx_inc[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    action_next     = action_t'(s_action);
                    key_next        = s_key;
                    idx_next        = '0;
                    res_status_next = 1'b0;
                    res_found_next  = 1'b0;
                    res_ivalid_next = 1'b0;
                    res_key_next    = '0;
                    state_next      = ST_DONE;
                    unique case (s_action)
                        ACT_APPEND: begin
                            if (held_reg == NONE_POS) begin
                                res_status_next = 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = held_reg[AW-1:0];
                                ram_wdata = s_key;
                                held_next = held_reg + CW'(1);
                                if (held_reg == '0) begin
                                    cursor_next = '0;
                                end
                            end
                        end
                        ACT_DELETE: begin
                            if (held_reg == '0) begin
                                res_status_next = 1'b1;
                            end else begin
                                ram_raddr  = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_MEMBER: begin
                            if (held_reg != '0) begin
                                ram_raddr  = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_HEAD: begin
                            if (held_reg != '0) begin
                                cursor_next = '0;
                                ram_raddr   = '0;
                                state_next  = ST_READ;
                            end
                        end
                        ACT_NEXT: begin
                            if (cursor_ok) begin
                                if (cursor_inc >= held_reg) begin
                                    cursor_next = NONE_POS;
                                end else begin
                                    cursor_next = cursor_inc;
                                    ram_raddr   = cursor_inc[AW-1:0];
                                    state_next  = ST_READ;
                                end
                            end
                        end
                        ACT_READ: begin
                            if (cursor_ok) begin
                                ram_raddr  = cursor_reg[AW-1:0];
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                            res_status_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (key_match) begin
                    if (action_reg == ACT_MEMBER) begin
                        res_found_next = 1'b1;
                        state_next     = ST_DONE;
                    end else begin
                        // first match found at idx_reg; fix the cursor, then close the gap
                        state_next = ST_SHIFT;
                        if (!cursor_ok) begin
                            cursor_next = NONE_POS;
                        end else if (cursor_reg == idx_reg) begin
                            if (cursor_inc >= held_reg) begin
                                cursor_next = NONE_POS;
                            end
                        end else if (cursor_reg > idx_reg) begin
                            ram_raddr  = cursor_reg[AW-1:0];
                            state_next = ST_CHECK;
                        end
                    end
                end else if (idx_inc >= held_reg) begin
                    res_status_next = (action_reg == ACT_DELETE);
                    state_next      = ST_DONE;
                end else begin
                    idx_next  = idx_inc;
                    ram_raddr = idx_inc[AW-1:0];
                end
            end
            ST_CHECK: begin
                // cursor lies past the removed slot
                if (key_match) begin
                    if (cursor_inc >= held_reg) begin
                        cursor_next = NONE_POS;
                    end
                end else begin
                    cursor_next = cursor_reg - CW'(1);
                end
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (idx_inc >= held_reg) begin
                    held_next  = held_reg - CW'(1);
                    state_next = ST_DONE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    idx_next  = idx_inc;
                    ram_raddr = idx_inc2[AW-1:0];
                end
            end
            ST_READ: begin
                res_ivalid_next = 1'b1;
                res_key_next    = ram_rdata;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_status_next     = res_status_reg;
                    m_found_next      = res_found_reg;
                    m_item_valid_next = res_ivalid_reg;
                    m_item_key_next   = res_key_reg;
                    m_count_next      = held_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            held_reg    <= '0;
            cursor_reg  <= NONE_POS;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg       <= action_next;
        key_reg          <= key_next;
        idx_reg          <= idx_next;
        res_status_reg   <= res_status_next;
        res_found_reg    <= res_found_next;
        res_ivalid_reg   <= res_ivalid_next;
        res_key_reg      <= res_key_next;
        m_status_reg     <= m_status_next;
        m_found_reg      <= m_found_next;
        m_item_valid_reg <= m_item_valid_next;
        m_item_key_reg   <= m_item_key_next;
        m_count_reg      <= m_count_next;
    end

    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= NONE_POS)
        else $error("held count beyond depth");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cursor_reg < held_reg) || (cursor_reg == NONE_POS))
        else $error("cursor neither on a stored key nor none");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_action == ACT_APPEND && held_reg != NONE_POS)
        |=> held_reg == $past(held_reg) + CW'(1))
        else $error("append did not grow the queue by one");

    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_SHIFT) || accept)
        else $error("entry write outside append or compaction");

    a_none_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item_valid) |-> m_item_key == '0)
        else $error("item key not zero without a cursor key");

endmodule

`default_nettype wire
